>>> rtl/core/pac_pkg.sv
// Shared types and constants of the proximity alarm controller.
// Used by every module in rtl/core but pac_ram; depends on nothing else.
`timescale 1ns / 1ps

package pac_pkg;

    localparam int SAMPLE_BITS       = 10;
    localparam int TABLE_ENTRIES_DEF = 40;
    localparam int FRAME_SAMPLES_DEF = 10;

    localparam int CFG_W       = 6;
    localparam int CFG_IDX_W   = 1;
    localparam int RANGE_W     = 6;
    localparam int BYTE_W      = 8;
    localparam int TIDX_W      = 6;
    localparam int TVAL_W      = 10;
    localparam int SUM_FIELD_W = 14;

    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 16;

    localparam int IN_SAMPLE_LSB = 0;
    localparam int IN_BYTE_LSB   = 10;
    localparam int IN_TIDX_LSB   = 18;
    localparam int IN_TVAL_LSB   = 24;

    localparam int OUT_RANGE_LSB = 3;
    localparam int OUT_MSG_LSB   = 9;
    localparam int OUT_MODE_LSB  = 12;
    localparam int OUT_DONE_BIT  = 14;

    localparam logic [TVAL_W-1:0]  NO_MATCH_LIMIT = 10'd1000;
    localparam logic [RANGE_W-1:0] RANGE_MAX      = 6'd63;
    localparam logic [CFG_W-1:0]   NEAR_RESET     = 6'd20;
    localparam logic [CFG_W-1:0]   MIN_RESET      = 6'd5;

    localparam logic [BYTE_W-1:0] CMD_ARM    = 8'h61;
    localparam logic [BYTE_W-1:0] CMD_DISARM = 8'h64;
    localparam logic [BYTE_W-1:0] CMD_REPORT = 8'h72;
    localparam logic [BYTE_W-1:0] CMD_LIGHTS = 8'h0D;

    localparam logic [CFG_IDX_W-1:0] CFG_NEAR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN  = 1'b1;

    localparam logic [2:0] LED_ALL   = 3'b111;
    localparam logic [2:0] LED_SAFE  = 3'b001;
    localparam logic [2:0] LED_WARN  = 3'b010;
    localparam logic [2:0] LED_ALERT = 3'b100;

    typedef enum logic [1:0] {
        OP_SAMPLE  = 2'd0,
        OP_COMMAND = 2'd1,
        OP_LOAD    = 2'd2,
        OP_SPARE   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        K_NONE    = 3'd0,
        K_FRAME   = 3'd1,
        K_ARM     = 3'd2,
        K_DISARM  = 3'd3,
        K_REPORT  = 3'd4,
        K_LIGHTS  = 3'd5,
        K_LOAD    = 3'd6
    } kind_t;

    typedef enum logic [1:0] {
        MODE_DISARMED = 2'd0,
        MODE_ARMED    = 2'd1,
        MODE_ALERT    = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        MSG_NONE     = 3'd0,
        MSG_ALERT    = 3'd1,
        MSG_ARMED    = 3'd2,
        MSG_DISARMED = 3'd3,
        MSG_REPORT   = 3'd4
    } msg_t;

    typedef struct packed {
        kind_t                  kind;
        logic [SUM_FIELD_W-1:0] sum;
        logic [TIDX_W-1:0]      tidx;
        logic [TVAL_W-1:0]      tval;
    } work_t;

endpackage

>>> rtl/core/pac_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module pac_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 40
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/pac_fifo.sv
// Two-entry queue of classified work between the front and back parts.
// Depends on pac_pkg for the work entry type.
`timescale 1ns / 1ps

module pac_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  pac_pkg::work_t push_data,
    output logic          full,
    input  logic          pop,
    output pac_pkg::work_t pop_data,
    output logic          empty
);
    import pac_pkg::*;

    work_t      mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/pac_front.sv
// Front part: accepts input beats, accumulates sample frames and classifies work.
// Depends on pac_pkg; feeds pac_fifo.
`timescale 1ns / 1ps

module pac_front #(
    parameter int FRAME_SAMPLES = pac_pkg::FRAME_SAMPLES_DEF,
    parameter int TABLE_ENTRIES = pac_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  pac_pkg::op_t                 in_op,
    input  logic [pac_pkg::S_DATA_W-1:0] in_data,
    output logic                         push,
    output pac_pkg::work_t               push_data,
    input  logic                         full
);
    import pac_pkg::*;

    localparam int SUM_W = $clog2(FRAME_SAMPLES * ((1 << SAMPLE_BITS) - 1) + 1);
    localparam int CNT_W = $clog2(FRAME_SAMPLES + 1);

    logic [SUM_W-1:0]       sum_reg;
    logic [SUM_W-1:0]       sum_next;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [SUM_W-1:0]       sum_inc;
    logic [CNT_W-1:0]       count_inc;
    logic [SAMPLE_BITS-1:0] sample;
    logic [BYTE_W-1:0]      rx_byte;
    logic [TIDX_W-1:0]      tidx;
    logic                   accept;

    assign in_ready  = !full;
    assign accept    = in_valid && !full;
    assign push      = accept;
    assign sample    = in_data[IN_SAMPLE_LSB +: SAMPLE_BITS];
    assign rx_byte   = in_data[IN_BYTE_LSB +: BYTE_W];
    assign tidx      = in_data[IN_TIDX_LSB +: TIDX_W];
    assign sum_inc   = sum_reg + SUM_W'(sample);
    assign count_inc = count_reg + CNT_W'(1);

    always_comb
    begin
        sum_next       = sum_reg;
        count_next     = count_reg;
        push_data.kind = K_NONE;
        push_data.sum  = SUM_FIELD_W'(sum_inc);
        push_data.tidx = tidx;
        push_data.tval = in_data[IN_TVAL_LSB +: TVAL_W];
        case (in_op)
            OP_SAMPLE:
            begin
                if (count_inc == CNT_W'(FRAME_SAMPLES))
                begin
                    push_data.kind = K_FRAME;
                    sum_next       = '0;
                    count_next     = '0;
                end
                else
                begin
                    sum_next   = sum_inc;
                    count_next = count_inc;
                end
            end
            OP_COMMAND:
            begin
                case (rx_byte)
                    CMD_ARM:    push_data.kind = K_ARM;
                    CMD_DISARM: push_data.kind = K_DISARM;
                    CMD_REPORT: push_data.kind = K_REPORT;
                    CMD_LIGHTS: push_data.kind = K_LIGHTS;
                    default:    push_data.kind = K_NONE;
                endcase
            end
            OP_LOAD:
            begin
                if ({1'b0, tidx} < 7'(TABLE_ENTRIES))
                begin
                    push_data.kind = K_LOAD;
                end
            end
            default:
            begin
                push_data.kind = K_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

endmodule

>>> rtl/core/pac_back.sv
// Back part: carries out queued work, scans the calibration table, runs the alarm modes.
// Depends on pac_pkg and pac_ram; holds the result register.
`timescale 1ns / 1ps

module pac_back #(
    parameter int FRAME_SAMPLES = pac_pkg::FRAME_SAMPLES_DEF,
    parameter int TABLE_ENTRIES = pac_pkg::TABLE_ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          empty,
    output logic                          pop,
    input  pac_pkg::work_t                pop_data,
    input  logic                          cfg_valid,
    input  logic [pac_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pac_pkg::CFG_W-1:0]     cfg_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [pac_pkg::M_DATA_W-1:0]  out_data
);
    import pac_pkg::*;

    localparam int SUM_W   = $clog2(FRAME_SAMPLES * ((1 << SAMPLE_BITS) - 1) + 1);
    localparam int FRAC    = SUM_W + $clog2(FRAME_SAMPLES);
    localparam int RECIP   = ((1 << FRAC) + FRAME_SAMPLES - 1) / FRAME_SAMPLES;
    localparam int RECIP_W = FRAC + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_EVAL = 4'b1000
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [SUM_W-1:0]       sum_reg;
    logic [SUM_W-1:0]       sum_next;
    logic [SAMPLE_BITS-1:0] avg_reg;
    logic [SAMPLE_BITS-1:0] avg_next;
    logic [IDX_W-1:0]       scan_idx_reg;
    logic [IDX_W-1:0]       scan_idx_next;
    logic [TVAL_W-1:0]      best_diff_reg;
    logic [TVAL_W-1:0]      best_diff_next;
    logic [IDX_W-1:0]       best_idx_reg;
    logic [IDX_W-1:0]       best_idx_next;
    mode_t                  mode_reg;
    mode_t                  mode_next;
    logic                   alert_sent_reg;
    logic                   alert_sent_next;
    logic                   lights_reg;
    logic                   lights_next;
    logic [2:0]             led_reg;
    logic [2:0]             led_next;
    logic [RANGE_W-1:0]     range_reg;
    logic [RANGE_W-1:0]     range_next;
    logic [CFG_W-1:0]       near_reg;
    logic [CFG_W-1:0]       near_next;
    logic [CFG_W-1:0]       min_reg;
    logic [CFG_W-1:0]       min_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [M_DATA_W-1:0]    out_data_reg;
    logic [M_DATA_W-1:0]    out_data_next;

    logic                   ram_we;
    logic                   ram_re;
    logic [IDX_W-1:0]       ram_raddr;
    logic [TVAL_W-1:0]      ram_rdata;
    logic [PROD_W-1:0]      prod;
    logic [TVAL_W-1:0]      diff;
    logic [RANGE_W:0]       dist_inc;
    logic [RANGE_W-1:0]     dist_sat;
    logic [RANGE_W-1:0]     dist_val;
    logic                   out_free;
    logic                   load_out;
    logic                   done;
    msg_t                   msg;

    pac_ram #(
        .WIDTH(TVAL_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(pop_data.tidx[IDX_W-1:0]),
        .wdata(pop_data.tval),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign prod     = PROD_W'(sum_reg) * PROD_W'(RECIP);
    assign diff     = (ram_rdata >= avg_reg) ? (ram_rdata - avg_reg) : (avg_reg - ram_rdata);
    assign dist_inc = (RANGE_W + 1)'(best_idx_reg) + 7'd1;
    assign dist_sat = (dist_inc > {1'b0, RANGE_MAX}) ? RANGE_MAX : dist_inc[RANGE_W-1:0];
    assign dist_val = (dist_sat < min_reg) ? min_reg : dist_sat;

    always_comb
    begin
        state_next      = state_reg;
        sum_next        = sum_reg;
        avg_next        = avg_reg;
        scan_idx_next   = scan_idx_reg;
        best_diff_next  = best_diff_reg;
        best_idx_next   = best_idx_reg;
        mode_next       = mode_reg;
        alert_sent_next = alert_sent_reg;
        lights_next     = lights_reg;
        led_next        = led_reg;
        range_next      = range_reg;
        near_next       = near_reg;
        min_next        = min_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        pop             = 1'b0;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = '0;
        load_out        = 1'b0;
        done            = 1'b0;
        msg             = MSG_NONE;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_NEAR: near_next = cfg_data;
                CFG_MIN:  min_next  = cfg_data;
                default:  near_next = near_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!empty && out_free)
                begin
                    pop = 1'b1;
                    case (pop_data.kind)
                        K_FRAME:
                        begin
                            sum_next   = pop_data.sum[SUM_W-1:0];
                            state_next = ST_DIV;
                        end
                        K_ARM:
                        begin
                            if (mode_reg != MODE_ALERT)
                            begin
                                mode_next = MODE_ARMED;
                                msg       = MSG_ARMED;
                            end
                            load_out = 1'b1;
                        end
                        K_DISARM:
                        begin
                            alert_sent_next = 1'b0;
                            mode_next       = MODE_DISARMED;
                            msg             = MSG_DISARMED;
                            load_out        = 1'b1;
                        end
                        K_REPORT:
                        begin
                            alert_sent_next = 1'b0;
                            msg             = MSG_REPORT;
                            load_out        = 1'b1;
                        end
                        K_LIGHTS:
                        begin
                            led_next    = LED_ALL;
                            lights_next = 1'b0;
                            load_out    = 1'b1;
                        end
                        K_LOAD:
                        begin
                            ram_we   = 1'b1;
                            load_out = 1'b1;
                        end
                        default:
                        begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                avg_next       = prod[FRAC +: SAMPLE_BITS];
                best_diff_next = NO_MATCH_LIMIT;
                best_idx_next  = '0;
                scan_idx_next  = '0;
                ram_re         = 1'b1;
                state_next     = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (diff < best_diff_reg)
                begin
                    best_diff_next = diff;
                    best_idx_next  = scan_idx_reg;
                end
                if (scan_idx_reg == IDX_W'(TABLE_ENTRIES - 1))
                begin
                    state_next = ST_EVAL;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + IDX_W'(1);
                    ram_re        = 1'b1;
                    ram_raddr     = scan_idx_reg + IDX_W'(1);
                end
            end
            ST_EVAL:
            begin
                if (out_free)
                begin
                    range_next = dist_val;
                    if (dist_val < near_reg)
                    begin
                        if (mode_reg == MODE_DISARMED)
                        begin
                            alert_sent_next = 1'b0;
                        end
                        else
                        begin
                            if (!alert_sent_reg)
                            begin
                                mode_next       = MODE_ALERT;
                                msg             = MSG_ALERT;
                                alert_sent_next = 1'b1;
                            end
                            led_next    = LED_ALERT;
                            lights_next = 1'b1;
                        end
                    end
                    else if (lights_reg)
                    begin
                        if (mode_reg == MODE_ARMED)
                        begin
                            led_next = LED_SAFE;
                        end
                        else if (mode_reg == MODE_DISARMED)
                        begin
                            led_next = LED_WARN;
                        end
                    end
                    done       = 1'b1;
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_data_next  = '0;
            out_data_next[2:0]                        = led_next;
            out_data_next[OUT_RANGE_LSB +: RANGE_W]   = range_next;
            out_data_next[OUT_MSG_LSB +: 3]           = msg;
            out_data_next[OUT_MODE_LSB +: 2]          = mode_next;
            out_data_next[OUT_DONE_BIT]               = done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            mode_reg       <= MODE_DISARMED;
            alert_sent_reg <= 1'b0;
            lights_reg     <= 1'b0;
            led_reg        <= LED_ALL;
            range_reg      <= '0;
            near_reg       <= NEAR_RESET;
            min_reg        <= MIN_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_reg       <= mode_next;
            alert_sent_reg <= alert_sent_next;
            lights_reg     <= lights_next;
            led_reg        <= led_next;
            range_reg      <= range_next;
            near_reg       <= near_next;
            min_reg        <= min_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg       <= sum_next;
        avg_reg       <= avg_next;
        scan_idx_reg  <= scan_idx_next;
        best_diff_reg <= best_diff_next;
        best_idx_reg  <= best_idx_next;
        out_data_reg  <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/core/proximity_alarm_controller_unit.sv
// A command, table load or non-final sample beat is queued in pac_fifo, then popped, and its
// result registered; a frame-completing sample runs ST_DIV, ST_SCAN and ST_EVAL after its pop.
// Input: one beat per cycle while the queue has room; frame-completing samples hold the back
// part while the single calibration RAM read port scans the table.
// Reset (rst_n, asynchronous, active low) disarms, lights all LEDs, clears the frame sum and
// range, and restores the registers; the calibration table stays undefined until loaded.
`timescale 1ns / 1ps

module proximity_alarm_controller_unit #(
    parameter int TABLE_ENTRIES = pac_pkg::TABLE_ENTRIES_DEF,
    parameter int FRAME_SAMPLES = pac_pkg::FRAME_SAMPLES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // sample_value[9:0], rx_byte[17:10], table_index[23:18], table_value[33:24], zeros above
    input  logic [pac_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // led_safe[0], led_warn[1], led_alert[2], range_inches[8:3], message_code[11:9],
    // alarm_mode[13:12], frame_done[14], zero[15]
    output logic [pac_pkg::M_DATA_W-1:0]  m_axis_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pac_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pac_pkg::CFG_W-1:0]     cfg_data
);
    import pac_pkg::*;

    logic  push;
    work_t push_data;
    logic  full;
    logic  pop;
    work_t pop_data;
    logic  empty;

    assign cfg_ready = 1'b1;

    pac_front #(
        .FRAME_SAMPLES(FRAME_SAMPLES),
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_op    (op_t'(s_axis_tuser)),
        .in_data  (s_axis_tdata),
        .push     (push),
        .push_data(push_data),
        .full     (full)
    );

    pac_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_data),
        .full     (full),
        .pop      (pop),
        .pop_data (pop_data),
        .empty    (empty)
    );

    pac_back #(
        .FRAME_SAMPLES(FRAME_SAMPLES),
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .empty    (empty),
        .pop      (pop),
        .pop_data (pop_data),
        .cfg_valid(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_data (m_axis_tdata)
    );

endmodule

>>> rtl/core/pac_checker.sv
// Port-level checks of the proximity alarm controller, bound to the top level.
// Depends on pac_pkg and proximity_alarm_controller_unit.
`timescale 1ns / 1ps

module pac_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [pac_pkg::M_DATA_W-1:0] m_axis_tdata
);
    import pac_pkg::*;

    logic [2:0] leds;
    logic [2:0] msg;
    logic [1:0] mode;
    logic       done;

    assign leds = m_axis_tdata[2:0];
    assign msg  = m_axis_tdata[OUT_MSG_LSB +: 3];
    assign mode = m_axis_tdata[OUT_MODE_LSB +: 2];
    assign done = m_axis_tdata[OUT_DONE_BIT];

    // A stalled result beat stays put.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed while stalled");

    // The LEDs are either all lit or exactly one is lit.
    a_leds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ($onehot(leds) || leds == LED_ALL))
        else $error("illegal LED pattern");

    // An alert message comes only with alert mode and the alert LED.
    a_alert: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && msg == MSG_ALERT |-> mode == MODE_ALERT && leds == LED_ALERT && done)
        else $error("alert message without alert state");

    // Command replies never mark a completed frame.
    a_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (msg == MSG_ARMED || msg == MSG_DISARMED || msg == MSG_REPORT)
        |-> !done)
        else $error("command reply flagged as frame");

endmodule

bind proximity_alarm_controller_unit pac_checker u_pac_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);
